@@ design/gffp_pkg.sv @@
// ============================================================================
// gffp_pkg: shared types and constants of the grid first-fit placer
// Holds the transaction payload structs, operation and register codes, and
// the command and status bundles between controller and datapath.
// ============================================================================
package gffp_pkg;

    // Default sizes of the occupancy bitmap and the largest rectangle side.
    localparam int MAX_COLUMNS_DEF   = 16;
    localparam int MAX_ROWS_DEF      = 16;
    localparam int MAX_RECT_SIDE_DEF = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] GRID_WIDTH_RST  = 5'd10;
    localparam logic [CFG_DATA_W-1:0] GRID_HEIGHT_RST = 5'd4;

    // Operation codes.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PLACE = 2'd1;
    localparam logic [1:0] OP_FIND  = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] corner_x;
        logic [3:0] corner_y;
        logic [2:0] rect_width;
        logic [2:0] rect_height;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [3:0] spot_x;
        logic [3:0] spot_y;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the incoming transaction
        logic clear;      // mark every column free
        logic rd;         // read the column at base plus offset
        logic wr;         // write back the column with the place mask merged in
        logic k_inc;      // advance the column offset
        logic col_start;  // start a new candidate column for find
        logic next_col;   // move find to the next column
        logic row_next;   // move find to the next row
        logic hit;        // record a fitting corner
        logic out_load;   // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] in_op;
        logic       place_done;
        logic       col_fit;
        logic       all_issued;
        logic       row_hit;
        logic       row_end;
        logic       out_free;
    } t_dp_sts;

endpackage

@@ design/grid_first_fit_placer_top.sv @@
// ============================================================================
// grid_first_fit_placer_top: two-dimensional first-fit grid allocator
// Keeps an occupancy bitmap of the grid; clears it, places rectangles on it
// and finds the first free corner that fits a rectangle, column by column.
// ============================================================================
// Place does a read-modify-write of one bitmap column per step, for each
// column of the rectangle. Find, for each candidate column, reads w columns
// through the single memory read port, then tests one candidate row per
// cycle. One transaction is in work at a time.
// Reset marks every cell free at once and sets the grid to 10 by 4 cells.

module grid_first_fit_placer_top #(
    parameter int MAX_COLUMNS   = gffp_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS      = gffp_pkg::MAX_ROWS_DEF,
    parameter int MAX_RECT_SIDE = gffp_pkg::MAX_RECT_SIDE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port: grid width at index 0, grid height at 1.
    input  logic                            i_cfg_we,
    input  logic [gffp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gffp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input transaction channel.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  gffp_pkg::t_in_item              i_in_data,
    // Result transaction channel; only find produces a result.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output gffp_pkg::t_out_item             o_out_data
);

    // Commands and status between the sequencer and the datapath.
    gffp_pkg::t_dp_cmd cmd;
    gffp_pkg::t_dp_sts sts;

    // The controller accepts a transaction only when it is idle. A pending
    // result sits in the datapath's output register, so a new transaction
    // may start while the previous result has not yet been taken; a find
    // that finishes waits before loading its result until the register is
    // free.
    gffp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // The datapath keeps one bitmap word per column. Place merges a row mask
    // into each touched column; find ORs the w columns of a candidate
    // window together and slides the rectangle height down that mask.
    gffp_dp #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_ROWS      (MAX_ROWS),
        .MAX_RECT_SIDE (MAX_RECT_SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ design/gffp_ctrl.sv @@
// ============================================================================
// gffp_ctrl: sequencing controller of the grid first-fit placer
// Steps through clear, place and find, one transaction at a time, and drives
// the datapath by command bits.
// ============================================================================
module gffp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output gffp_pkg::t_dp_cmd o_cmd,
    input  gffp_pkg::t_dp_sts i_sts
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_PL_RD   = 3'd1;
    localparam logic [2:0] S_PL_WR   = 3'd2;
    localparam logic [2:0] S_FD_COL  = 3'd3;
    localparam logic [2:0] S_FD_RD   = 3'd4;
    localparam logic [2:0] S_FD_SCAN = 3'd5;
    localparam logic [2:0] S_FD_OUT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_sts.in_op)
                        gffp_pkg::OP_CLEAR: o_cmd.clear = 1'b1;
                        gffp_pkg::OP_PLACE: n_state = S_PL_RD;
                        gffp_pkg::OP_FIND:  n_state = S_FD_COL;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_PL_RD: begin
                if (i_sts.place_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_PL_WR;
                end
            end
            S_PL_WR: begin
                o_cmd.wr    = 1'b1;
                o_cmd.k_inc = 1'b1;
                n_state     = S_PL_RD;
            end
            S_FD_COL: begin
                if (i_sts.col_fit) begin
                    o_cmd.col_start = 1'b1;
                    n_state         = S_FD_RD;
                end else begin
                    n_state = S_FD_OUT;
                end
            end
            S_FD_RD: begin
                if (i_sts.all_issued) begin
                    n_state = S_FD_SCAN;
                end else begin
                    o_cmd.rd    = 1'b1;
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_FD_SCAN: begin
                priority if (i_sts.row_hit) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_FD_OUT;
                end else if (i_sts.row_end) begin
                    o_cmd.next_col = 1'b1;
                    n_state        = S_FD_COL;
                end else begin
                    o_cmd.row_next = 1'b1;
                end
            end
            S_FD_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/gffp_dp.sv @@
// ============================================================================
// gffp_dp: datapath of the grid first-fit placer
// Holds the grid size registers, the column bitmap memory with per-column
// valid bits, the scan counters, the window mask and the result register.
// ============================================================================
module gffp_dp #(
    parameter int MAX_COLUMNS   = gffp_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS      = gffp_pkg::MAX_ROWS_DEF,
    parameter int MAX_RECT_SIDE = gffp_pkg::MAX_RECT_SIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gffp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gffp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  gffp_pkg::t_in_item                  i_in_data,
    input  gffp_pkg::t_dp_cmd                   i_cmd,
    output gffp_pkg::t_dp_sts                   o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output gffp_pkg::t_out_item                 o_out_data
);

    localparam int XCW = $clog2(MAX_COLUMNS + MAX_RECT_SIDE + 32);
    localparam int YCW = $clog2(MAX_ROWS + MAX_RECT_SIDE + 32);
    localparam int SW  = $clog2(MAX_RECT_SIDE + 8);
    localparam int XAW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // Grid size registers.
    logic [gffp_pkg::CFG_DATA_W-1:0] r_grid_width;
    logic [gffp_pkg::CFG_DATA_W-1:0] r_grid_height;
    logic [XCW-1:0]                  cols;
    logic [YCW-1:0]                  rows;

    // Transaction and scan registers.
    logic [XCW-1:0]      r_x;
    logic [SW-1:0]       r_k;
    logic [YCW-1:0]      r_y;
    logic [SW-1:0]       r_w;
    logic [SW-1:0]       r_h;
    logic [MAX_ROWS-1:0] r_pmask;
    logic [MAX_ROWS-1:0] r_win;
    logic                r_hit;

    // Bitmap memory, one word per column, and its valid bits.
    logic [MAX_ROWS-1:0]    mem [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] r_colv;
    logic [MAX_ROWS-1:0]    r_rd_data;
    logic                   r_rd_v;
    logic                   r_rd_pend;

    logic                r_out_valid;
    gffp_pkg::t_out_item r_out;

    logic [SW-1:0]       side_w;
    logic [SW-1:0]       side_h;
    logic [MAX_ROWS-1:0] pmask_in;
    logic [MAX_ROWS-1:0] hmask;
    logic [XCW-1:0]      col_x;
    logic [XAW-1:0]      addr;
    logic [MAX_ROWS-1:0] rd_word;

    always_comb begin
        cols = (XCW'(r_grid_width) > XCW'(MAX_COLUMNS)) ? XCW'(MAX_COLUMNS)
                                                       : XCW'(r_grid_width);
        rows = (YCW'(r_grid_height) > YCW'(MAX_ROWS)) ? YCW'(MAX_ROWS)
                                                      : YCW'(r_grid_height);
    end

    // A side of zero counts as one; large sides saturate.
    always_comb begin
        side_w = SW'(i_in_data.rect_width);
        if (i_in_data.rect_width == 3'd0) begin
            side_w = SW'(1);
        end else if (side_w > SW'(MAX_RECT_SIDE)) begin
            side_w = SW'(MAX_RECT_SIDE);
        end
        side_h = SW'(i_in_data.rect_height);
        if (i_in_data.rect_height == 3'd0) begin
            side_h = SW'(1);
        end else if (side_h > SW'(MAX_RECT_SIDE)) begin
            side_h = SW'(MAX_RECT_SIDE);
        end
    end

    // Rows covered by a place, clipped to the grid.
    always_comb begin
        for (int i = 0; i < MAX_ROWS; i++) begin
            pmask_in[i] = (i >= int'(i_in_data.corner_y))
                       && (i < int'(i_in_data.corner_y) + int'(side_h))
                       && (i < int'(rows));
        end
    end

    // Rows of the rectangle height, counted from the current scan row.
    always_comb begin
        for (int i = 0; i < MAX_ROWS; i++) begin
            hmask[i] = (i < int'(r_h));
        end
    end

    assign col_x   = r_x + XCW'(r_k);
    assign addr    = col_x[XAW-1:0];
    assign rd_word = r_rd_v ? r_rd_data : '0;

    always_comb begin
        o_sts            = '0;
        o_sts.in_op      = i_in_data.opcode;
        o_sts.place_done = (r_k == r_w) || (col_x >= cols);
        o_sts.col_fit    = (r_x + XCW'(r_w)) <= cols;
        o_sts.all_issued = (r_k == r_w);
        o_sts.row_end    = (r_y + YCW'(r_h)) > rows;
        o_sts.row_hit    = ((r_win & hmask) == '0) && !o_sts.row_end;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= gffp_pkg::GRID_WIDTH_RST;
            r_grid_height <= gffp_pkg::GRID_HEIGHT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == gffp_pkg::CFG_GRID_WIDTH) begin
                r_grid_width <= i_cfg_data;
            end else if (i_cfg_index == gffp_pkg::CFG_GRID_HEIGHT) begin
                r_grid_height <= i_cfg_data;
            end
        end
    end

    // Bitmap memory: one read and one write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[addr] <= rd_word | r_pmask;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[addr];
            r_rd_v    <= r_colv[addr];
        end
    end

    // Valid bits: a column that is not valid reads as free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colv    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd;
            if (i_cmd.clear) begin
                r_colv <= '0;
            end else if (i_cmd.wr) begin
                r_colv[addr] <= 1'b1;
            end
        end
    end

    // Scan counters and window mask.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= (i_in_data.opcode == gffp_pkg::OP_PLACE) ?
                       XCW'(i_in_data.corner_x) : '0;
            r_k     <= '0;
            r_y     <= '0;
            r_w     <= side_w;
            r_h     <= side_h;
            r_pmask <= pmask_in;
        end else begin
            if (i_cmd.k_inc) begin
                r_k <= r_k + SW'(1);
            end
            if (i_cmd.col_start) begin
                r_k <= '0;
                r_y <= '0;
            end
            if (i_cmd.next_col) begin
                r_x <= r_x + XCW'(1);
            end
            if (i_cmd.row_next) begin
                r_y <= r_y + YCW'(1);
            end
        end
        if (i_cmd.col_start) begin
            r_win <= '0;
        end else if (i_cmd.row_next) begin
            r_win <= r_win >> 1;
        end else if (r_rd_pend) begin
            r_win <= r_win | rd_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit <= 1'b0;
        end else if (i_cmd.hit) begin
            r_hit <= 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.found  <= r_hit;
            r_out.spot_x <= r_hit ? 4'(r_x) : 4'd0;
            r_out.spot_y <= r_hit ? 4'(r_y) : 4'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ tb/tb_top.sv @@
// ============================================================================
// tb_top: self-checking testbench of the grid first-fit placer
// Drives clear, place and find transactions through the valid/ready input
// channel, predicts find results from a bitmap model or a typed answer, and
// checks the results in order while both channels idle and stall at random.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gffp_pkg::*;

    // Opcode 3 has no meaning; the block must swallow it without a result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int unsigned GRID_COLS   = MAX_COLUMNS_DEF;
    localparam int unsigned GRID_ROWS   = MAX_ROWS_DEF;
    localparam int unsigned SIDE_LIMIT  = MAX_RECT_SIDE_DEF;
    // This margin after the last accepted transaction covers a place of the
    // widest rectangle before a register write or the end.
    localparam int unsigned SETTLE      = 32;
    localparam int unsigned PHASES      = 12;
    localparam int unsigned PHASE_ITEMS = 94;
    // The slowest find tries every candidate column, reading its window and scanning its rows. With receiver
    // stalls and sender gaps about 1150 transactions need well under this limit,
    // so it leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    grid_first_fit_placer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Grid model. cell_map[x][y] is set when the cell is occupied. The grid
    // size registers are mirrored here whenever the testbench writes them.
    // ------------------------------------------------------------------------
    logic [GRID_ROWS-1:0]  cell_map [GRID_COLS];
    logic [CFG_DATA_W-1:0] model_cols_reg;
    logic [CFG_DATA_W-1:0] model_rows_reg;

    // Find results still owed by the block, oldest first.
    t_out_item spot_queue [$];

    int unsigned error_count   = 0;
    int unsigned sent_count    = 0;
    int unsigned checked_count = 0;
    int unsigned hit_count     = 0;
    int unsigned cycle_count   = 0;
    int unsigned burst_left    = 0;
    int unsigned settings_used = 1;

    // Grid sizes above the bitmap saturate; zero leaves an empty grid.
    function automatic int unsigned grid_cols();
        return (model_cols_reg > GRID_COLS) ? GRID_COLS : int'(model_cols_reg);
    endfunction

    function automatic int unsigned grid_rows();
        return (model_rows_reg > GRID_ROWS) ? GRID_ROWS : int'(model_rows_reg);
    endfunction

    // A rectangle side of zero counts as one cell; long sides are cut to
    // the largest supported side.
    function automatic int unsigned side_len(logic [2:0] v);
        if (v == 3'd0)
            return 1;
        return (v > SIDE_LIMIT) ? SIDE_LIMIT : int'(v);
    endfunction

    // True when the whole rectangle lies inside the grid and is free.
    function automatic bit rect_free(int unsigned x0, int unsigned y0, int unsigned w,
                                     int unsigned h, int unsigned cols, int unsigned rows);
        if (x0 + w > cols || y0 + h > rows)
            return 1'b0;
        for (int unsigned x = x0; x < x0 + w; x++)
            for (int unsigned y = y0; y < y0 + h; y++)
                if (cell_map[x][y])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Applies one accepted transaction to the model. A find reports the first
    // fitting corner, scanning columns outermost and rows within each column.
    task automatic grid_apply(input t_in_item it, output bit gives, output t_out_item res);
        int unsigned cols;
        int unsigned rows;
        int unsigned w;
        int unsigned h;
        int unsigned cx;
        int unsigned cy;
        cols  = grid_cols();
        rows  = grid_rows();
        w     = side_len(it.rect_width);
        h     = side_len(it.rect_height);
        cx    = 32'(it.corner_x);
        cy    = 32'(it.corner_y);
        gives = 1'b0;
        res   = '0;
        case (it.opcode)
            OP_CLEAR: begin
                for (int unsigned x = 0; x < GRID_COLS; x++)
                    cell_map[x] = '0;
            end
            OP_PLACE: begin
                // Cells past the grid edge are simply dropped.
                for (int unsigned x = cx; x < cx + w && x < cols; x++)
                    for (int unsigned y = cy; y < cy + h && y < rows; y++)
                        cell_map[x][y] = 1'b1;
            end
            OP_FIND: begin
                gives = 1'b1;
                for (int unsigned x = 0; x < cols; x++)
                    for (int unsigned y = 0; y < rows; y++)
                        if (!res.found && rect_free(x, y, w, h, cols, rows)) begin
                            res.found  = 1'b1;
                            res.spot_x = 4'(x);
                            res.spot_y = 4'(y);
                        end
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result checking. Every accepted result transaction is compared with
    // the oldest outstanding find prediction.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    t_out_item owed_spot;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (spot_queue.size() == 0) begin
                report_mismatch("result with no find outstanding, found", o_out_data.found, 0);
            end else begin
                owed_spot = spot_queue.pop_front();
                checked_count++;
                if (owed_spot.found)
                    hit_count++;
                if (o_out_data.found !== owed_spot.found)
                    report_mismatch("found", o_out_data.found, owed_spot.found);
                if (o_out_data.spot_x !== owed_spot.spot_x)
                    report_mismatch("spot_x", o_out_data.spot_x, owed_spot.spot_x);
                if (o_out_data.spot_y !== owed_spot.spot_y)
                    report_mismatch("spot_y", o_out_data.spot_y, owed_spot.spot_y);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver back-pressure. Whenever the current style's stretch ends, a new
    // stall style is picked: always ready, coin flips, a repeating pattern from an
    // 8-bit mask, or long stalls where ready rarely rises. The always-ready style
    // gives stretches with no stalls at all.
    // ------------------------------------------------------------------------
    int unsigned stall_left    = 0;
    int unsigned stall_style   = 0;
    logic [7:0]  stall_pattern = 8'hFF;
    logic [2:0]  stall_phase   = 3'd0;

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 3'd1;
        if (stall_left == 0) begin
            stall_left    <= $urandom_range(20, 80);
            stall_style   <= $urandom_range(0, 3);
            stall_pattern <= 8'($urandom) | 8'h01;
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= stall_pattern[stall_phase];
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // A hung block ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d find results still outstanding.",
                     cycle_count, spot_queue.size());
            $display("grid_first_fit_placer_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender pacing. Transactions go out in bursts of random length; between
    // bursts valid drops for a random gap, or not at all, so that gaps land
    // on every phase of the block's work.
    // ------------------------------------------------------------------------
    task automatic next_slot();
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Presents one transaction and holds it until the block takes it. The
    // prediction is made at the acceptance edge. A row with a hand-written
    // answer pushes that answer in place of the model's.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        bit        gives;
        t_out_item res;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        grid_apply(it, gives, res);
        if (gives)
            spot_queue.push_back(typed ? typed_res : res);
        sent_count++;
    endtask

    // Grid size writes happen only with the block idle: all finds answered
    // and time for a trailing place or clear to finish.
    task automatic program_grid(input logic [CFG_DATA_W-1:0] cols,
                                input logic [CFG_DATA_W-1:0] rows);
        while (spot_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_GRID_WIDTH;
        i_cfg_data  <= cols;
        @(posedge i_clk);
        i_cfg_index <= CFG_GRID_HEIGHT;
        i_cfg_data  <= rows;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        model_cols_reg  = cols;
        model_rows_reg  = rows;
        settings_used++;
    endtask

    // Random transaction, weighted toward place and find on the grid in use
    // so the bitmap fills up and finds have to search. Clears are rare so
    // the grid gets crowded between them; a few unused opcodes are mixed in.
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        int unsigned cols;
        int unsigned rows;
        cols           = grid_cols();
        rows           = grid_rows();
        pick           = $urandom_range(0, 99);
        it.corner_x    = 4'($urandom_range(0, 15));
        it.corner_y    = 4'($urandom_range(0, 15));
        it.rect_width  = 3'($urandom_range(0, 7));
        it.rect_height = 3'($urandom_range(0, 7));
        if (pick < 3) begin
            it.opcode = OP_CLEAR;
        end else if (pick < 6) begin
            it.opcode = OP_UNUSED;
        end else if (pick < 50) begin
            it.opcode = OP_PLACE;
            // Mostly aim the corner inside the grid; the rest goes anywhere.
            if (cols != 0 && $urandom_range(0, 4) != 0)
                it.corner_x = 4'($urandom_range(0, cols - 1));
            if (rows != 0 && $urandom_range(0, 4) != 0)
                it.corner_y = 4'($urandom_range(0, rows - 1));
        end else begin
            it.opcode = OP_FIND;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table. Each row is one transaction; rows marked typed carry
    // the answer written out by hand, all others are predicted by the model.
    // ------------------------------------------------------------------------
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_directed_row;

    t_directed_row directed_rows [$];

    task automatic add_row(input logic [1:0] op, input int cx, input int cy, input int w,
                           input int h, input bit typed = 1'b0, input bit found = 1'b0,
                           input int sx = 0, input int sy = 0);
        t_directed_row row;
        row.item.opcode      = op;
        row.item.corner_x    = 4'(cx);
        row.item.corner_y    = 4'(cy);
        row.item.rect_width  = 3'(w);
        row.item.rect_height = 3'(h);
        row.typed            = typed;
        row.want.found       = found;
        row.want.spot_x      = 4'(sx);
        row.want.spot_y      = 4'(sy);
        directed_rows.push_back(row);
    endtask

    // Grid sizes of the random phases: the largest grid, an empty grid in
    // each direction, the smallest grid, oversize values that saturate, thin
    // strips, an odd size, then random sizes. Occupancy carries across them.
    logic [CFG_DATA_W-1:0] phase_cols [PHASES];
    logic [CFG_DATA_W-1:0] phase_rows [PHASES];

    initial begin
        int unsigned counted;
        t_in_item    it;
        t_out_item   none;

        none        = '0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_GRID_WIDTH;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;

        for (int unsigned x = 0; x < GRID_COLS; x++)
            cell_map[x] = '0;
        model_cols_reg = GRID_WIDTH_RST;
        model_rows_reg = GRID_HEIGHT_RST;

        // The directed part runs on the reset grid of 10 by 4 cells.
        add_row(OP_FIND,   0,  0, 1, 1, 1'b1, 1'b1, 0, 0);   // empty grid, 1x1 at the origin
        add_row(OP_FIND,   0,  0, 0, 0, 1'b1, 1'b1, 0, 0);   // zero sides count as one
        add_row(OP_FIND,   0,  0, 7, 7, 1'b1, 1'b1, 0, 0);   // long sides cut to 4x4
        add_row(OP_PLACE,  0,  0, 4, 4);
        add_row(OP_FIND,   5, 10, 1, 1);                     // first free column after it
        add_row(OP_PLACE,  8,  2, 4, 4);                     // runs past the right and top
        add_row(OP_PLACE, 15, 15, 7, 7);                     // wholly off the grid
        add_row(OP_UNUSED, 15, 15, 7, 7);                    // swallowed, no result
        add_row(OP_FIND,  10,  5, 4, 4);
        add_row(OP_FIND,   0,  0, 2, 2);
        add_row(OP_FIND,  15, 15, 1, 6);
        add_row(OP_FIND,   0,  0, 5, 1);
        add_row(OP_CLEAR,  0,  0, 0, 0);
        add_row(OP_FIND,   0,  0, 4, 4, 1'b1, 1'b1, 0, 0);   // clear freed everything
        add_row(OP_PLACE,  0,  0, 4, 4);
        add_row(OP_PLACE,  4,  0, 4, 4);
        add_row(OP_PLACE,  8,  0, 4, 4);
        add_row(OP_FIND,   0,  0, 1, 1, 1'b1, 1'b0, 0, 0);   // full grid, nothing fits
        add_row(OP_FIND,  15, 15, 0, 0, 1'b1, 1'b0, 0, 0);
        add_row(OP_CLEAR, 15, 15, 7, 7);
        add_row(OP_PLACE,  9,  3, 1, 1);                     // last cell only
        add_row(OP_FIND,   0,  0, 4, 4, 1'b1, 1'b1, 0, 0);

        phase_cols = '{5'd16, 5'd0, 5'd4, 5'd1, 5'd31, 5'd16, 5'd1, 5'd7, 5'd0, 5'd0, 5'd0, 5'd0};
        phase_rows = '{5'd16, 5'd4, 5'd0, 5'd1, 5'd31, 5'd1, 5'd16, 5'd3, 5'd0, 5'd0, 5'd0, 5'd0};
        for (int unsigned p = 8; p < PHASES; p++) begin
            phase_cols[p] = 5'($urandom_range(1, 16));
            phase_rows[p] = 5'($urandom_range(1, 16));
        end

        // Synchronous reset.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            next_slot();
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        end
        i_in_valid <= 1'b0;

        // Random phases, one per grid setting. Unused opcodes do not count
        // toward the transactions of a phase.
        for (int unsigned p = 0; p < PHASES; p++) begin
            program_grid(phase_cols[p], phase_rows[p]);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                it = random_item();
                next_slot();
                send_item(it, 1'b0, none);
                if (it.opcode != OP_UNUSED)
                    counted++;
            end
            i_in_valid <= 1'b0;
        end

        // Drain: every find answered, then time for a trailing place.
        while (spot_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (spot_queue.size() != 0)
            report_mismatch("find results left unanswered", spot_queue.size(), 0);

        $display("Run covered %0d transactions over %0d grid settings in %0d cycles.",
                 sent_count, settings_used, cycle_count);
        $display("%0d find results checked, %0d of them with a fitting spot, %0d mismatches.",
                 checked_count, hit_count, error_count);
        if (error_count == 0) begin
            $display("grid_first_fit_placer_top verification clean");
        end else begin
            $display("grid_first_fit_placer_top verification failed");
        end
        $finish;
    end

endmodule
